// ===== rtl/early_exit_threshold_histogram_defines.svh =====
// Assertion macros for the early-exit threshold histogram block.
// Used by the top level only; expects signals named clk and rst in scope.
`ifndef EARLY_EXIT_THRESHOLD_HISTOGRAM_DEFINES_SVH
`define EARLY_EXIT_THRESHOLD_HISTOGRAM_DEFINES_SVH

// Condition must never be true outside reset.
`define EETH_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define EETH_ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== rtl/eeth_pkg.sv =====
// Shared types and constants for the early-exit threshold histogram block.
// No dependencies; every module file imports this package.
`timescale 1ns / 1ps

package eeth_pkg;

  // Head indexes and counts fit in the width of the points_in_use register.
  localparam int HEAD_W     = 4;
  localparam int HEAD_LIMIT = 15;
  // Cost table slots addressable by a 3-bit cost_slot.
  localparam int COST_SLOTS = 8;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 32;

  // Register indexes on the configuration port.
  localparam logic [CFG_INDEX_W-1:0] REG_THRESHOLD = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_POINTS    = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_SAMPLES   = 2'd2;

  // Input command codes.
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_CONF = 1'b1;

  // Queue entry kinds.
  localparam logic KIND_LOAD   = 1'b0;
  localparam logic KIND_SAMPLE = 1'b1;

  localparam logic [14:0] THRESHOLD_RESET = 15'd328;
  localparam logic [3:0]  POINTS_RESET    = 4'd8;
  localparam logic [31:0] SAMPLES_RESET   = 32'd1;

  typedef struct packed {
    logic        command;
    logic [14:0] confidence;
    logic [2:0]  cost_slot;
    logic [63:0] cost_word;
  } in_t;

  typedef struct packed {
    logic [2:0]  winning_head;
    logic        catastrophe;
    logic [31:0] bin_total;
    logic [31:0] catastrophe_total;
    logic [63:0] cost_total;
    logic        run_done;
  } out_t;

  typedef struct packed {
    logic [14:0] confidence_threshold;
    logic [3:0]  points_in_use;
    logic [31:0] samples_in_run;
  } cfg_t;

  typedef struct packed {
    logic              kind;
    logic              catastrophe;
    logic [HEAD_W-1:0] head;
    logic [2:0]        slot;
    logic [63:0]       word;
  } entry_t;

endpackage

// ===== rtl/eeth_front.sv =====
// Front end: accepts input words, tracks the exit heads of the current sample
// and pushes cost loads and finished samples into the queue. Uses eeth_pkg.
`timescale 1ns / 1ps

module eeth_front
  import eeth_pkg::*;
#(
  parameter int MAX_HEADS = 8
) (
  input  logic   clk,
  input  logic   rst,
  input  cfg_t   cfg,
  input  logic   in_valid,
  output logic   in_ready,
  input  in_t    in_data,
  input  logic   q_full,
  output logic   q_push,
  output entry_t q_entry
);

  localparam int HeadCap   = (MAX_HEADS < HEAD_LIMIT) ? MAX_HEADS : HEAD_LIMIT;
  localparam int CostDepth = (MAX_HEADS < COST_SLOTS) ? MAX_HEADS : COST_SLOTS;
  localparam logic [HEAD_W-1:0] HeadCapV = HEAD_W'(HeadCap);

  logic [HEAD_W-1:0] pos;
  logic              settled;
  logic [HEAD_W-1:0] chosen;

  logic              accept;
  logic [HEAD_W-1:0] heads;
  logic              hit;
  logic              settled_now;
  logic [HEAD_W-1:0] chosen_now;
  logic [HEAD_W:0]   pos_inc;
  logic [HEAD_W:0]   last_pos;
  logic              last;
  logic              slot_ok;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    if (cfg.points_in_use < HEAD_W'(2)) begin
      heads = HEAD_W'(2);
    end else if (cfg.points_in_use > HeadCapV) begin
      heads = HeadCapV;
    end else begin
      heads = cfg.points_in_use;
    end
  end

  assign hit         = !settled && (in_data.confidence >= cfg.confidence_threshold);
  assign settled_now = settled || hit;
  assign chosen_now  = settled ? chosen : pos;
  assign pos_inc     = {1'b0, pos} + (HEAD_W+1)'(1);
  assign last_pos    = {1'b0, heads} - (HEAD_W+1)'(1);
  // A shrunken head count mid-sample also ends the sample here.
  assign last        = pos_inc >= last_pos;
  assign slot_ok     = 32'(in_data.cost_slot) < CostDepth;

  always_comb begin
    q_entry.kind        = KIND_LOAD;
    q_entry.catastrophe = 1'b0;
    q_entry.head        = '0;
    q_entry.slot        = in_data.cost_slot;
    q_entry.word        = in_data.cost_word;
    q_push              = 1'b0;
    if (accept) begin
      if (in_data.command == CMD_LOAD) begin
        // drop loads beyond the table
        q_push = slot_ok;
      end else if (last) begin
        q_push              = 1'b1;
        q_entry.kind        = KIND_SAMPLE;
        q_entry.catastrophe = !settled_now;
        q_entry.head        = settled_now ? chosen_now : last_pos[HEAD_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos     <= '0;
      settled <= 1'b0;
      chosen  <= '0;
    end else if (accept && in_data.command == CMD_CONF) begin
      if (last) begin
        pos     <= '0;
        settled <= 1'b0;
        chosen  <= '0;
      end else begin
        pos     <= pos_inc[HEAD_W-1:0];
        settled <= settled_now;
        chosen  <= chosen_now;
      end
    end
  end

endmodule

// ===== rtl/eeth_queue.sv =====
// Two-entry queue between front and back end.
// Uses entry_t from eeth_pkg.
`timescale 1ns / 1ps

module eeth_queue
  import eeth_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t push_entry,
  output logic   full,
  input  logic   pop,
  output logic   empty,
  output entry_t head
);

  localparam int Depth = 2;
  localparam int PtrW  = $clog2(Depth);

  entry_t          entries [Depth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [PtrW:0]   count;

  assign full  = count == (PtrW+1)'(Depth);
  assign empty = count == '0;
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PtrW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PtrW'(1);
      end
      if (push && !pop) begin
        count <= count + (PtrW+1)'(1);
      end else if (pop && !push) begin
        count <= count - (PtrW+1)'(1);
      end
    end
  end

endmodule

// ===== rtl/eeth_back.sv =====
// Back end: applies cost loads, updates histogram, counters and cost total
// for each finished sample, and holds the result word. Uses eeth_pkg.
`timescale 1ns / 1ps

module eeth_back
  import eeth_pkg::*;
#(
  parameter int MAX_HEADS = 8
) (
  input  logic   clk,
  input  logic   rst,
  input  cfg_t   cfg,
  input  logic   q_empty,
  input  entry_t q_head,
  output logic   q_pop,
  output logic   out_valid,
  input  logic   out_ready,
  output out_t   out_data
);

  localparam int NumBins   = (MAX_HEADS < HEAD_LIMIT) ? MAX_HEADS : HEAD_LIMIT;
  localparam int BinW      = $clog2(NumBins);
  localparam int CostDepth = (MAX_HEADS < COST_SLOTS) ? MAX_HEADS : COST_SLOTS;
  localparam int CostIdxW  = $clog2(CostDepth);

  logic [31:0] hist [NumBins];
  logic [63:0] cost_table [CostDepth];
  logic [31:0] cat_count;
  logic [63:0] cost_sum;
  logic [31:0] seen;

  logic          out_free;
  logic          pop_load;
  logic          pop_sample;
  logic [BinW-1:0] bin_idx;
  logic [63:0]   cost_rd;
  logic [31:0]   bin_next;
  logic [31:0]   cat_next;
  logic [63:0]   cost_next;
  logic [31:0]   seen_inc;
  logic          done;

  assign out_free   = !out_valid || out_ready;
  assign pop_load   = !q_empty && q_head.kind == KIND_LOAD;
  assign pop_sample = !q_empty && q_head.kind == KIND_SAMPLE && out_free;
  assign q_pop      = pop_load || pop_sample;

  assign bin_idx = q_head.head[BinW-1:0];

  always_comb begin
    if (32'(q_head.head) < CostDepth) begin
      cost_rd = cost_table[q_head.head[CostIdxW-1:0]];
    end else begin
      cost_rd = '0;
    end
  end

  assign bin_next  = hist[bin_idx] + 32'd1;
  assign cat_next  = cat_count + 32'(q_head.catastrophe);
  assign cost_next = cost_sum + cost_rd;
  assign seen_inc  = seen + 32'd1;
  assign done      = seen_inc == cfg.samples_in_run;

  always_ff @(posedge clk) begin
    if (pop_load) begin
      cost_table[q_head.slot[CostIdxW-1:0]] <= q_head.word;
    end
  end

  always_ff @(posedge clk) begin
    if (pop_sample) begin
      out_data.winning_head      <= q_head.head[2:0];
      out_data.catastrophe       <= q_head.catastrophe;
      out_data.bin_total         <= bin_next;
      out_data.catastrophe_total <= cat_next;
      out_data.cost_total        <= cost_next;
      out_data.run_done          <= done;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NumBins; i++) begin
        hist[i] <= '0;
      end
      cat_count <= '0;
      cost_sum  <= '0;
      seen      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (pop_sample) begin
        hist[bin_idx] <= bin_next;
        cat_count     <= cat_next;
        cost_sum      <= cost_next;
        seen          <= done ? 32'd0 : seen_inc;
        out_valid     <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/early_exit_threshold_histogram.sv =====
// Top level of the early-exit threshold histogram block: configuration
// registers, front end, queue and back end. Uses eeth_pkg and the defines header.
`timescale 1ns / 1ps
`include "early_exit_threshold_histogram_defines.svh"

// Each sample is heads-1 confidence words, one per exit head in order, with
// heads = points_in_use clamped to 2..min(MAX_HEADS, 15); the first head at
// or above confidence_threshold wins, otherwise the last head wins and the
// sample counts as a catastrophe. Load words (command 0) fill the 64-bit cost
// table and may come at any time; they give no result. The block takes one
// input word per clock unless the queue is full: the front end classifies
// each word in the cycle it is accepted, and loads and finished samples pass
// a two-entry queue to the back end, which updates the winner's histogram
// bin, the catastrophe count, the 64-bit cost total and the run counter as
// it pops the sample and places the result word in an output register. The
// queue fills, and input stalls, only while the output register is held by
// out_ready. Configuration is written through cfg_we / cfg_index / cfg_data
// and takes effect on the next word; no clearing pass is needed after reset.
module early_exit_threshold_histogram
  import eeth_pkg::*;
#(
  parameter int MAX_HEADS = 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  in_t                    in_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output out_t                   out_data,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  cfg_t   cfg;
  logic   q_push;
  entry_t q_entry;
  logic   q_full;
  logic   q_pop;
  logic   q_empty;
  entry_t q_head;
  logic   sample_pop;

  // Configuration registers; an index beyond the list is dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.confidence_threshold <= THRESHOLD_RESET;
      cfg.points_in_use        <= POINTS_RESET;
      cfg.samples_in_run       <= SAMPLES_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_THRESHOLD: cfg.confidence_threshold <= cfg_data[14:0];
        REG_POINTS:    cfg.points_in_use        <= cfg_data[3:0];
        REG_SAMPLES:   cfg.samples_in_run       <= cfg_data[31:0];
        default: begin
        end
      endcase
    end
  end

  // Front end: head tracking and classification.
  eeth_front #(
    .MAX_HEADS(MAX_HEADS)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data (in_data),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_entry (q_entry)
  );

  // Decouple front from back so each side can stall on its own.
  eeth_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_entry(q_entry),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .head      (q_head)
  );

  // Back end: cost table, histogram, totals and the result register.
  eeth_back #(
    .MAX_HEADS(MAX_HEADS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .q_empty  (q_empty),
    .q_head   (q_head),
    .q_pop    (q_pop),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  // A finished sample leaves the queue this cycle.
  assign sample_pop = q_pop && q_head.kind == KIND_SAMPLE;

  // Queue never overflows or underflows.
  `EETH_ASSERT_NEVER(a_no_push_full, q_push && q_full && !q_pop, "push into full queue")
  `EETH_ASSERT_NEVER(a_no_pop_empty, q_pop && q_empty, "pop from empty queue")
  // A new result only follows a finished sample leaving the queue.
  `EETH_ASSERT_IMPLIES(a_result_source, $rose(out_valid), $past(sample_pop), "orphan result")

endmodule
